// ----- design/dsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_pkg: shared types and constants for the divisor-sum block
// Holds the default number width and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsf_pkg;

  // Default width of the input number.
  localparam int NUMBER_BITS_DEF = 32;

  // Operand pairing for the shared serial multiplier.
  typedef enum logic [1:0] {
    MSEL_POWER_CAND = 2'd0,
    MSEL_TOTAL_GEO  = 2'd1,
    MSEL_TOTAL_REST = 2'd2
  } mul_sel_e;

  // Commands from the controller; each flag is a single-cycle pulse, while mul_sel is held.
  typedef struct packed {
    logic     load;
    logic     sq;
    logic     div_start;
    logic     div_take;
    logic     mul_start;
    logic     mul_take;
    logic     next_cand;
    logic     out_load;
    mul_sel_e mul_sel;
  } dsf_cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic sq_le_rest;
    logic rest_gt1;
    logic div_busy;
    logic rem_zero;
    logic mul_busy;
  } dsf_stat_t;

endpackage

// ----- design/dsf_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_divider: bit-serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder are valid once
// busy falls.
// ----------------------------------------------------------------------------
module dsf_divider #(
  parameter int DIVIDEND_BITS = 32,
  parameter int DIVISOR_BITS  = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]  divisor_i,
  output logic                     busy_o,
  output logic [DIVIDEND_BITS-1:0] quotient_o,
  output logic [DIVISOR_BITS-1:0]  remainder_o
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                     busy_q;
  logic [CNT_BITS-1:0]      cnt_q;
  logic [DIVIDEND_BITS-1:0] quo_q;
  logic [DIVISOR_BITS-1:0]  rem_q;
  logic [DIVISOR_BITS-1:0]  dvs_q;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, quo_q[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  // Step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_BITS'(DIVIDEND_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= diff[DIVISOR_BITS-1:0];
        quo_q <= {quo_q[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem_q <= trial[DIVISOR_BITS-1:0];
        quo_q <= {quo_q[DIVIDEND_BITS-2:0], 1'b0};
      end
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- design/dsf_multiplier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_multiplier: shift-and-add serial multiplier
// Consumes one bit of the B operand per cycle and stops early once the
// remaining B bits are all zero. The product is kept to A_BITS bits.
// ----------------------------------------------------------------------------
module dsf_multiplier #(
  parameter int A_BITS = 35,
  parameter int B_BITS = 33
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [A_BITS-1:0] a_i,
  input  logic [B_BITS-1:0] b_i,
  output logic              busy_o,
  output logic [A_BITS-1:0] product_o
);

  logic              busy_q;
  logic [A_BITS-1:0] acc_q;
  logic [A_BITS-1:0] a_sh_q;
  logic [B_BITS-1:0] b_sh_q;
  logic              b_left;

  assign b_left = (b_sh_q != '0);

  // Busy until every set bit of B has been consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && !b_left) begin
      busy_q <= 1'b0;
    end
  end

  // Accumulate the shifted A operand for each set bit of B.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      a_sh_q <= a_i;
      b_sh_q <= b_i;
    end else if (busy_q && b_left) begin
      if (b_sh_q[0]) begin
        acc_q <= acc_q + a_sh_q;
      end
      a_sh_q <= {a_sh_q[A_BITS-2:0], 1'b0};
      b_sh_q <= {1'b0, b_sh_q[B_BITS-1:1]};
    end
  end

  assign busy_o    = busy_q;
  assign product_o = acc_q;

endmodule

// ----- design/dsf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_datapath: factorization datapath
// Holds the remaining value, trial candidate, running product and geometric
// sum, plus the serial divider and serial multiplier that work on them.
// ----------------------------------------------------------------------------
module dsf_datapath import dsf_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [NUMBER_BITS-1:0] number_in_i,
  input  dsf_cmd_t               cmd_i,
  output dsf_stat_t              stat_o,
  output logic [NUMBER_BITS+2:0] divisor_sum_o
);

  localparam int SUM_BITS  = NUMBER_BITS + 3;
  localparam int CAND_BITS = (NUMBER_BITS + 1) / 2 + 1;
  localparam int SQ_BITS   = 2 * CAND_BITS;
  localparam int MB_BITS   = NUMBER_BITS + 1;

  logic [NUMBER_BITS-1:0] rest_q;
  logic [CAND_BITS-1:0]   cand_q;
  logic [SQ_BITS-1:0]     square_q;
  logic [SUM_BITS-1:0]    total_q;
  logic [NUMBER_BITS-1:0] power_q;
  logic [MB_BITS-1:0]     geo_q;
  logic [SUM_BITS-1:0]    sum_q;

  logic                   div_busy;
  logic [NUMBER_BITS-1:0] div_quo;
  logic [CAND_BITS-1:0]   div_rem;

  logic [SUM_BITS-1:0]    mul_a;
  logic [MB_BITS-1:0]     mul_b;
  logic                   mul_busy;
  logic [SUM_BITS-1:0]    mul_prod;

  // Trial division of the remaining value by the current candidate.
  dsf_divider #(
    .DIVIDEND_BITS(NUMBER_BITS),
    .DIVISOR_BITS (CAND_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rest_q),
    .divisor_i  (cand_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.mul_sel)
      MSEL_POWER_CAND: begin
        mul_a = SUM_BITS'(power_q);
        mul_b = MB_BITS'(cand_q);
      end
      MSEL_TOTAL_GEO: begin
        mul_a = total_q;
        mul_b = geo_q;
      end
      MSEL_TOTAL_REST: begin
        mul_a = total_q;
        mul_b = MB_BITS'(rest_q) + MB_BITS'(1);
      end
      default: begin
        mul_a = total_q;
        mul_b = '0;
      end
    endcase
  end

  dsf_multiplier #(
    .A_BITS(SUM_BITS),
    .B_BITS(MB_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .busy_o   (mul_busy),
    .product_o(mul_prod)
  );

  // Working registers, updated by controller commands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rest_q  <= number_in_i;
      cand_q  <= CAND_BITS'(2);
      total_q <= SUM_BITS'(number_in_i != '0);
      power_q <= NUMBER_BITS'(1);
      geo_q   <= MB_BITS'(1);
    end
    if (cmd_i.next_cand) begin
      cand_q  <= (cand_q == CAND_BITS'(2)) ? CAND_BITS'(3) : cand_q + CAND_BITS'(2);
      power_q <= NUMBER_BITS'(1);
      geo_q   <= MB_BITS'(1);
    end
    if (cmd_i.sq) begin
      square_q <= SQ_BITS'(cand_q) * SQ_BITS'(cand_q);
    end
    if (cmd_i.div_take) begin
      rest_q <= div_quo;
    end
    if (cmd_i.mul_take) begin
      case (cmd_i.mul_sel)
        MSEL_POWER_CAND: begin
          power_q <= mul_prod[NUMBER_BITS-1:0];
          geo_q   <= geo_q + mul_prod[MB_BITS-1:0];
        end
        MSEL_TOTAL_GEO, MSEL_TOTAL_REST: begin
          total_q <= mul_prod;
        end
        default: begin
          total_q <= total_q;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      sum_q <= total_q;
    end
  end

  // Status back to the controller.
  assign stat_o.sq_le_rest = (square_q <= SQ_BITS'(rest_q));
  assign stat_o.rest_gt1   = (rest_q > NUMBER_BITS'(1));
  assign stat_o.div_busy   = div_busy;
  assign stat_o.rem_zero   = (div_rem == '0);
  assign stat_o.mul_busy   = mul_busy;

  assign divisor_sum_o = sum_q;

endmodule

// ----- design/dsf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_ctrl: sequencing controller
// Walks the trial candidates, runs the divide and multiply steps and manages
// the input and output handshakes.
// ----------------------------------------------------------------------------
module dsf_ctrl import dsf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dsf_stat_t stat_i,
  output dsf_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQ_WAIT,
    S_CMP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_OUT,
    S_PUSH
  } state_e;

  state_e   state_q;
  dsf_cmd_t cmd_q;
  mul_sel_e msel_q;
  logic     found_q;
  logic     out_valid_q;

  // State, command pulses and output valid. A command issued here is carried
  // out by the datapath at the end of the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      msel_q      <= MSEL_POWER_CAND;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmd_q         <= '0;
      cmd_q.mul_sel <= msel_q;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            found_q <= 1'b0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          cmd_q.sq <= 1'b1;
          state_q  <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          state_q <= S_CMP;
        end
        // Divide while the candidate squared fits in the remaining value.
        S_CMP: begin
          if (stat_i.sq_le_rest) begin
            cmd_q.div_start <= 1'b1;
            state_q         <= S_DIV_GO;
          end else if (stat_i.rest_gt1) begin
            cmd_q.mul_start <= 1'b1;
            cmd_q.mul_sel   <= MSEL_TOTAL_REST;
            msel_q          <= MSEL_TOTAL_REST;
            state_q         <= S_MUL_GO;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (!stat_i.div_busy) begin
            if (stat_i.rem_zero) begin
              cmd_q.div_take  <= 1'b1;
              cmd_q.mul_start <= 1'b1;
              cmd_q.mul_sel   <= MSEL_POWER_CAND;
              msel_q          <= MSEL_POWER_CAND;
              found_q         <= 1'b1;
              state_q         <= S_MUL_GO;
            end else if (found_q) begin
              cmd_q.mul_start <= 1'b1;
              cmd_q.mul_sel   <= MSEL_TOTAL_GEO;
              msel_q          <= MSEL_TOTAL_GEO;
              state_q         <= S_MUL_GO;
            end else begin
              cmd_q.next_cand <= 1'b1;
              state_q         <= S_SQ;
            end
          end
        end
        S_MUL_GO: begin
          state_q <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (!stat_i.mul_busy) begin
            cmd_q.mul_take <= 1'b1;
            case (msel_q)
              MSEL_POWER_CAND: begin
                cmd_q.div_start <= 1'b1;
                state_q         <= S_DIV_GO;
              end
              MSEL_TOTAL_GEO: begin
                cmd_q.next_cand <= 1'b1;
                found_q         <= 1'b0;
                state_q         <= S_SQ;
              end
              default: begin
                state_q <= S_OUT;
              end
            endcase
          end
        end
        // Load the output register once it is free or being freed.
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            cmd_q.out_load <= 1'b1;
            state_q        <= S_PUSH;
          end
        end
        S_PUSH: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The number is loaded at the accepting edge itself, so the load command
  // goes straight out instead of through the command register.
  always_comb begin
    cmd_o      = cmd_q;
    cmd_o.load = in_valid_i && (state_q == S_IDLE);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/divisor_sum_by_factorization_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divisor_sum_by_factorization_top: sum of divisors by trial factorization
// Returns sigma(n), the sum of all positive divisors of the input number.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o, number_in_i) takes one number
//   per transfer; the output channel (out_valid_o/out_ready_i,
//   divisor_sum_o) returns exactly one sum per number, in order. An input of
//   zero returns zero.
//   One number is worked at a time. Each trial candidate (2, then odd
//   numbers) is tested by the bit-serial divider, which yields one
//   quotient bit per cycle; candidates run until the candidate squared
//   exceeds the remaining value, up to about 2^(NUMBER_BITS/2 - 1) of
//   them. Each found factor costs a further division and a serial multiply.
//   Reset returns the block to idle with no result pending.
//   The finished sum sits in an output register, so a stalled receiver does
//   not stop the next number from being taken; the following result waits
//   until the previous one has been transferred.
// ----------------------------------------------------------------------------
module divisor_sum_by_factorization_top import dsf_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [NUMBER_BITS-1:0] number_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [NUMBER_BITS+2:0] divisor_sum_o
);

  dsf_cmd_t  cmd;
  dsf_stat_t stat;

  // Sequencing and handshakes.
  dsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and working registers.
  dsf_datapath #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .number_in_i  (number_in_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .divisor_sum_o(divisor_sum_o)
  );

endmodule

// ----- design/dsf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_checker: port-level checks for the divisor-sum block
// Watches the top-level handshakes and the one-at-a-time sequencing.
// ----------------------------------------------------------------------------
module dsf_checker import dsf_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [NUMBER_BITS-1:0] number_in_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [NUMBER_BITS+2:0] divisor_sum_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_o;

  // A waiting number keeps its value until it is taken.
  a_in_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> $stable(number_in_i))
    else $error("number_in_i changed while waiting");

  // A stalled result stays offered.
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before transfer");

  // A stalled result keeps its value.
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(divisor_sum_o))
    else $error("divisor_sum_o changed while stalled");

  // Only one number is in work at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input accepted while a number is in work");

  // A new result cannot appear right after a number is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result raised immediately after input transfer");

endmodule

bind divisor_sum_by_factorization_top dsf_checker #(
  .NUMBER_BITS(NUMBER_BITS)
) u_dsf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .number_in_i  (number_in_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .divisor_sum_o(divisor_sum_o)
);
